>>> src/slot_pkg.sv
`timescale 1ns / 1ps

package slot_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 4096;

    localparam int unsigned FUNC_W  = 1;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned SEP_W   = 13;
    localparam int unsigned LEFT_W  = 13;
    localparam int unsigned RIGHT_W = 14;
    localparam int unsigned IW_W    = 13;

    localparam logic [IW_W-1:0]   IMAGE_WIDTH_RST = 13'd4096;
    localparam logic [FUNC_W-1:0] FUNC_INIT       = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_LINK       = 1'b1;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load;      // capture an accepted input beat
        logic calc;      // derive left/right columns and range check
        logic init_wr;   // write self links at position
        logic rd;        // read both tables at right / left
        logic wr_a;      // evaluate and write the pair entries
        logic wr_b;      // break the deeper partners
        logic out_load;  // move the result into the output register
    } t_slot_cmd;

    // status back to the sequencer
    typedef struct packed {
        logic is_link;
        logic in_range;
        logic out_free;
    } t_slot_sts;

endpackage

>>> src/slot_ctrl.sv
`timescale 1ns / 1ps

module slot_ctrl
    import slot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_slot_sts i_sts,
    output t_slot_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_EVAL,
        S_FIX,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (i_sts.is_link) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.init_wr = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.in_range ? S_EVAL : S_DONE;
            end
            S_EVAL: begin
                o_cmd.wr_a = 1'b1;
                n_state    = S_FIX;
            end
            S_FIX: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_in_stall = r_busy;

endmodule

>>> src/slot_dp.sv
`timescale 1ns / 1ps

module slot_dp
    import slot_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_slot_cmd                 i_cmd,
    output t_slot_sts                 o_sts,
    input  logic [IW_W-1:0]           i_image_width,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [POS_W-1:0]          i_position,
    input  logic [SEP_W-1:0]          i_separation,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_in_range,
    output logic                      o_linked,
    output logic signed [LEFT_W-1:0]  o_left_pos,
    output logic signed [RIGHT_W-1:0] o_right_pos
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [AW-1:0] mem_r2l [MAX_WIDTH];
    logic [AW-1:0] mem_l2r [MAX_WIDTH];

    logic [FUNC_W-1:0]  r_func;
    logic [POS_W-1:0]   r_pos;
    logic [SEP_W-1:0]   r_sep;
    logic [LEFT_W-1:0]  r_left;
    logic [RIGHT_W-1:0] r_right;
    logic               r_in_range;
    logic [AW-1:0]      r_rd_r2l;
    logic [AW-1:0]      r_rd_l2r;
    logic               r_brk1;
    logic               r_brk2;
    logic               r_vis;
    logic               r_out_valid;
    logic               r_o_in_range;
    logic               r_o_linked;
    logic [LEFT_W-1:0]  r_o_left;
    logic [RIGHT_W-1:0] r_o_right;

    logic [LEFT_W-1:0]  n_left;
    logic [RIGHT_W-1:0] n_right;
    logic               n_in_range;
    logic [AW-1:0]      l_idx, r_idx, pos_idx;
    logic               pos_ok;
    logic               hit1, hit2, brk1, brk2, vis;
    logic               is_link;

    logic               r2l_we, l2r_we;
    logic [AW-1:0]      r2l_addr, l2r_addr, r2l_wdata, l2r_wdata;

    assign is_link = (r_func == FUNC_LINK);

    // left = x - floor(sep/2), right = left + sep
    always_comb begin
        n_left  = {1'b0, r_pos} - {1'b0, r_sep[SEP_W-1:1]};
        n_right = {n_left[LEFT_W-1], n_left} + {1'b0, r_sep};
        n_in_range = !n_left[LEFT_W-1]
                   && (n_right[RIGHT_W-2:0] < i_image_width)
                   && (32'(n_right[RIGHT_W-2:0]) < 32'(MAX_WIDTH));
    end

    assign l_idx   = AW'(r_left[LEFT_W-2:0]);
    assign r_idx   = AW'(r_right[RIGHT_W-2:0]);
    assign pos_idx = AW'(r_pos);
    assign pos_ok  = (32'(r_pos) < 32'(MAX_WIDTH));

    // a self link means unlinked; a partner that is not deeper hides the pair
    always_comb begin
        hit1 = (r_rd_r2l != r_idx);
        brk1 = hit1 && (r_rd_r2l < l_idx);
        hit2 = (r_rd_l2r != l_idx);
        brk2 = hit2 && (r_rd_l2r > r_idx);
        vis  = !(hit1 && !brk1) && !(hit2 && !brk2);
    end

    always_comb begin
        r2l_we    = 1'b0;
        l2r_we    = 1'b0;
        r2l_addr  = r_idx;
        l2r_addr  = l_idx;
        r2l_wdata = r_idx;
        l2r_wdata = l_idx;
        if (i_cmd.init_wr) begin
            r2l_we    = pos_ok;
            l2r_we    = pos_ok;
            r2l_addr  = pos_idx;
            l2r_addr  = pos_idx;
            r2l_wdata = pos_idx;
            l2r_wdata = pos_idx;
        end else if (i_cmd.wr_a) begin
            r2l_we    = vis || brk1;
            l2r_we    = vis || brk2;
            r2l_wdata = vis ? l_idx : r_idx;
            l2r_wdata = vis ? r_idx : l_idx;
        end else if (i_cmd.wr_b) begin
            r2l_we    = r_brk2;
            l2r_we    = r_brk1;
            r2l_addr  = r_rd_l2r;
            l2r_addr  = r_rd_r2l;
            r2l_wdata = r_rd_l2r;
            l2r_wdata = r_rd_r2l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2l_we) begin
            mem_r2l[r2l_addr] <= r2l_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_r2l <= mem_r2l[r2l_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (l2r_we) begin
            mem_l2r[l2r_addr] <= l2r_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_l2r <= mem_l2r[l2r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_sep  <= i_separation;
        end
        if (i_cmd.calc) begin
            r_left     <= n_left;
            r_right    <= n_right;
            r_in_range <= n_in_range;
        end
        if (i_cmd.wr_a) begin
            r_brk1 <= brk1;
            r_brk2 <= brk2;
            r_vis  <= vis;
        end
        if (i_cmd.out_load) begin
            r_o_in_range <= is_link && r_in_range;
            r_o_linked   <= is_link && r_in_range && r_vis;
            r_o_left     <= is_link ? r_left : '0;
            r_o_right    <= is_link ? r_right : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.is_link  = is_link;
    assign o_sts.in_range = r_in_range;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_in_range  = r_o_in_range;
    assign o_linked    = r_o_linked;
    assign o_left_pos  = r_o_left;
    assign o_right_pos = r_o_right;

endmodule

>>> src/stereo_link_occlusion_table.sv
`timescale 1ns / 1ps

// hidden-surface link tables for one scanline of a random-dot stereogram
// input channel: i_in_valid / o_in_stall with func, position, separation;
//   func init makes both entries at position self links, func link derives
//   a left/right pair and links it unless a nearer link hides it
// output channel: o_out_valid / i_out_stall, one result beat per input beat
// config channel: i_cfg_valid / o_cfg_ready writes image_width, always ready;
//   write it only while no item is in flight
// one item at a time, stepped by a sequencer over two single-port tables:
//   init: calc + self-link write, result; out of range: calc, read, result;
//   link: calc, read both tables, write pairs, break deeper partners, result
// result appears in the output register the cycle after the sequencer ends;
//   the next item is taken while that result waits
// a stalled result holds the sequencer in its last step, so at most one
//   further item is started behind it
// reset: sequencer idle, no result valid, image_width 4096; table contents
//   are undefined until init items write them
module stereo_link_occlusion_table
    import slot_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [IW_W-1:0]           i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [POS_W-1:0]          i_position,
    input  logic [SEP_W-1:0]          i_separation,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_in_range,
    output logic                      o_linked,
    output logic signed [LEFT_W-1:0]  o_left_pos,
    output logic signed [RIGHT_W-1:0] o_right_pos
);

    logic [IW_W-1:0] r_image_width;
    t_slot_cmd       cmd;
    t_slot_sts       sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_image_width <= i_cfg_data;
        end
    end

    slot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    slot_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_image_width (r_image_width),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_separation  (i_separation),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_in_range    (o_in_range),
        .o_linked      (o_linked),
        .o_left_pos    (o_left_pos),
        .o_right_pos   (o_right_pos)
    );

endmodule
